[rtl/wrsp_pkg.sv]
// Shared types and constants for the weighted random size picker.
// Used by wrsp_recip, wrsp_cell and weighted_random_size_picker_core.
package wrsp_pkg;

  // Fixed field widths
  localparam int TIME_W     = 32;
  localparam int RAND_W     = 31;
  localparam int SIZE_W     = 5;
  localparam int IDX_W      = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  // Reciprocal of a Q16.16 time: 2^32 / t produces 33 quotient bits
  localparam int DIV_STEPS = 33;
  localparam logic [TIME_W-1:0] RECIP_ONE = 32'h0001_0000;

  // Request function codes
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_DRAW = 1'b1;

  // Weighting modes
  localparam logic MODE_BASIC   = 1'b0;
  localparam logic MODE_INVERSE = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_COUNT  = 1'b1;

  // Control broadcast from the sequencer to every cell
  typedef struct packed {
    logic              wr_en;
    logic [IDX_W-1:0]  wr_idx;
    logic [TIME_W-1:0] wr_data;
    logic              mode;
    logic              div_start;
    logic              div_step;
    logic              div_first;
    logic              chain_en;
    logic              add_time;
    logic              add_flag;
    logic              wgt_en;
    logic              cmp_en;
  } cell_ctrl_t;

endpackage

[rtl/wrsp_recip.sv]
// Bit-serial restoring divider giving floor(2^32 / t), saturated, per cell.
// Depends on wrsp_pkg.
module wrsp_recip import wrsp_pkg::*; (
  input  logic              clk,
  input  logic              start,
  input  logic              step,
  input  logic              first,
  input  logic [TIME_W-1:0] divisor,
  output logic [TIME_W-1:0] recip
);

  logic [TIME_W-1:0] rem_r;
  logic [TIME_W-1:0] quo_r;
  logic [TIME_W:0]   rem_ext;
  logic [TIME_W:0]   diff;
  logic              fits;

  // Dividend is 2^32: only the first bit shifted in is a one
  assign rem_ext = {rem_r, first};
  assign diff    = rem_ext - {1'b0, divisor};
  assign fits    = (rem_ext >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= '0;
    end else if (step) begin
      rem_r <= fits ? diff[TIME_W-1:0] : rem_ext[TIME_W-1:0];
      quo_r <= {quo_r[TIME_W-2:0], fits};
    end
  end

  // Zero time weighs 1.0; a time of one LSB saturates
  always_comb begin
    if (divisor == '0) begin
      recip = RECIP_ONE;
    end else if (divisor == TIME_W'(1)) begin
      recip = '1;
    end else begin
      recip = quo_r;
    end
  end

endmodule

[rtl/wrsp_cell.sv]
// One cell of the picker row: holds one turnaround time, its weight and
// one stage of the shared chain register. Depends on wrsp_pkg, wrsp_recip.
module wrsp_cell import wrsp_pkg::*; #(
  parameter int IDX = 0,
  parameter int SW  = 36,
  parameter int TW  = 40,
  parameter int NW  = 5
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cell_ctrl_t            ctrl,
  input  logic [NW-1:0]         n_eff,
  input  logic [SW-1:0]         sum_in,
  input  logic [RAND_W+TW-1:0]  x_in,
  input  logic [TW-1:0]         chain_in,
  output logic [TW-1:0]         chain_out
);

  localparam int XW = RAND_W + TW;

  logic [TIME_W-1:0] time_r;
  logic [SW-1:0]     w_r;
  logic [TW-1:0]     chain_r;
  logic              flag_r;
  logic [TIME_W-1:0] recip;
  logic              active;
  logic [TW-1:0]     addend;
  logic [XW:0]       lhs;
  logic [XW:0]       rhs;

  assign active = (32'(n_eff) > 32'(IDX));

  // Stored turnaround time, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_r <= '0;
    end else if (ctrl.wr_en && (int'(ctrl.wr_idx) == IDX)) begin
      time_r <= ctrl.wr_data;
    end
  end

  wrsp_recip u_recip (
    .clk     (clk),
    .start   (ctrl.div_start),
    .step    (ctrl.div_step),
    .first   (ctrl.div_first),
    .divisor (time_r),
    .recip   (recip)
  );

  // Weight of this entry; unused entries weigh nothing
  always_ff @(posedge clk) begin
    if (ctrl.wgt_en) begin
      if (!active) begin
        w_r <= '0;
      end else if (ctrl.mode == MODE_INVERSE) begin
        w_r <= SW'(recip);
      end else if (sum_in == '0) begin
        w_r <= SW'(1);
      end else begin
        w_r <= sum_in - SW'(time_r);
      end
    end
  end

  // Chain stage: running sum of times, then of weights, then of flags
  always_comb begin
    if (ctrl.add_time) begin
      addend = active ? TW'(time_r) : '0;
    end else if (ctrl.add_flag) begin
      addend = TW'(flag_r);
    end else begin
      addend = TW'(w_r);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.chain_en) begin
      chain_r <= chain_in + addend;
    end
  end

  assign chain_out = chain_r;

  // Bucket passed: next * (2^31 - 1) <= rand * total
  assign lhs = (XW+1)'(x_in) + (XW+1)'(chain_r);
  assign rhs = (XW+1)'(chain_r) << RAND_W;

  always_ff @(posedge clk) begin
    if (ctrl.cmp_en) begin
      flag_r <= active && (lhs >= rhs);
    end
  end

endmodule

[rtl/weighted_random_size_picker_core.sv]
// Weighted random package-size picker, top level: sequencer, registers and
// the row of wrsp_cell instances. Depends on wrsp_pkg and wrsp_cell.
//
// A load request (func 0) writes one turnaround time and gives no result.
// A draw request (func 1) runs from acceptance to the result register
// through the 33-step bit-serial reciprocal that runs in every cell
// alongside the walk that sums the times, then the weight update, one walk
// along the cell row for the weight prefixes, a split multiply of random
// value by total, one compare step and a last walk that counts the
// passed buckets. One request is in work at a time; a new request is taken
// as soon as the draw result sits in the output register, even if it has
// not been taken. Configuration writes are taken at any time but must only
// be made while the block is idle.
module weighted_random_size_picker_core import wrsp_pkg::*; #(
  parameter int MAX_SIZES = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // request channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_func,
  input  logic [IDX_W-1:0]      in_entry_index,
  input  logic [TIME_W-1:0]     in_turnaround,
  input  logic [RAND_W-1:0]     in_random_value,
  // result channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [SIZE_W-1:0]     out_package_size,
  // configuration channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int LW    = $clog2(MAX_SIZES);
  localparam int SW    = TIME_W + LW;
  localparam int TW    = SW + LW;
  localparam int NW    = $clog2(MAX_SIZES + 1);
  localparam int XW    = RAND_W + TW;
  localparam int PLO_W = RAND_W + 32;
  localparam int PHI_W = RAND_W + TW - 32;
  localparam int L1    = (MAX_SIZES > DIV_STEPS) ? MAX_SIZES : DIV_STEPS;
  localparam int CNT_W = $clog2(L1);

  typedef enum logic [8:0] {
    PH_IDLE = 9'b000000001,
    PH_PREP = 9'b000000010,
    PH_WGT  = 9'b000000100,
    PH_PFX  = 9'b000001000,
    PH_MUL1 = 9'b000010000,
    PH_MUL2 = 9'b000100000,
    PH_CMP  = 9'b001000000,
    PH_CNT  = 9'b010000000,
    PH_DONE = 9'b100000000
  } phase_t;

  phase_t             ph_r, ph_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               mode_r;
  logic [4:0]         size_count_r;
  logic               out_valid_r;
  logic [SIZE_W-1:0]  out_size_r;
  logic [RAND_W-1:0]  rand_r;
  logic [PLO_W-1:0]   plo_r;
  logic [PHI_W-1:0]   phi_r;
  logic [XW-1:0]      x_r;
  logic [NW-1:0]      n_eff;
  logic [NW-1:0]      count;
  logic [SIZE_W-1:0]  size_nxt;
  logic [TW-1:0]      total;
  logic               in_acc;
  logic               out_load;
  cell_ctrl_t         ctrl;
  logic [TW-1:0]      chain_w [MAX_SIZES];

  assign in_ready         = (ph_r == PH_IDLE);
  assign in_acc           = in_valid && in_ready;
  assign cfg_ready        = 1'b1;
  assign out_valid        = out_valid_r;
  assign out_package_size = out_size_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_BASIC;
      size_count_r <= 5'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_WEIGHT_MODE: mode_r       <= cfg_data[0];
        CFG_SIZE_COUNT:  size_count_r <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // Sizes in use: zero counts as one, capped at the row length
  always_comb begin
    if (size_count_r == '0) begin
      n_eff = NW'(1);
    end else if (int'(size_count_r) > MAX_SIZES) begin
      n_eff = NW'(MAX_SIZES);
    end else begin
      n_eff = NW'(size_count_r);
    end
  end

  // Phase sequencer
  always_comb begin
    ph_nxt  = ph_r;
    cnt_nxt = cnt_r;
    case (ph_r)
      PH_IDLE: begin
        cnt_nxt = '0;
        if (in_acc && (in_func == FUNC_DRAW)) begin
          ph_nxt = PH_PREP;
        end
      end
      PH_PREP: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(L1 - 1)) begin
          cnt_nxt = '0;
          ph_nxt  = PH_WGT;
        end
      end
      PH_WGT: ph_nxt = PH_PFX;
      PH_PFX: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(MAX_SIZES - 1)) begin
          cnt_nxt = '0;
          ph_nxt  = PH_MUL1;
        end
      end
      PH_MUL1: ph_nxt = PH_MUL2;
      PH_MUL2: ph_nxt = PH_CMP;
      PH_CMP:  ph_nxt = PH_CNT;
      PH_CNT: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(MAX_SIZES - 1)) begin
          cnt_nxt = '0;
          ph_nxt  = PH_DONE;
        end
      end
      PH_DONE: begin
        if (out_load) begin
          ph_nxt = PH_IDLE;
        end
      end
      default: begin
        ph_nxt  = PH_IDLE;
        cnt_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r  <= PH_IDLE;
      cnt_r <= '0;
    end else begin
      ph_r  <= ph_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Cell control broadcast
  always_comb begin
    ctrl.wr_en     = in_acc && (in_func == FUNC_LOAD);
    ctrl.wr_idx    = in_entry_index;
    ctrl.wr_data   = in_turnaround;
    ctrl.mode      = mode_r;
    ctrl.div_start = in_acc && (in_func == FUNC_DRAW);
    ctrl.div_step  = (ph_r == PH_PREP) && (cnt_r < CNT_W'(DIV_STEPS));
    ctrl.div_first = (cnt_r == '0);
    ctrl.chain_en  = (ph_r == PH_PREP) || (ph_r == PH_PFX) || (ph_r == PH_CNT);
    ctrl.add_time  = (ph_r == PH_PREP);
    ctrl.add_flag  = (ph_r == PH_CNT);
    ctrl.wgt_en    = (ph_r == PH_WGT);
    ctrl.cmp_en    = (ph_r == PH_CMP);
  end

  // Row of cells, chain enters at cell 0 with zero
  for (genvar i = 0; i < MAX_SIZES; i++) begin : g_cell
    wrsp_cell #(
      .IDX (i),
      .SW  (SW),
      .TW  (TW),
      .NW  (NW)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .n_eff     (n_eff),
      .sum_in    (chain_w[MAX_SIZES-1][SW-1:0]),
      .x_in      (x_r),
      .chain_in  ((i == 0) ? TW'(0) : chain_w[(i == 0) ? 0 : i-1]),
      .chain_out (chain_w[i])
    );
  end

  // Draw operand and split product rand * total
  assign total = chain_w[MAX_SIZES-1];

  always_ff @(posedge clk) begin
    if (in_acc) begin
      rand_r <= in_random_value;
    end
    if (ph_r == PH_MUL1) begin
      plo_r <= PLO_W'(rand_r) * PLO_W'(total[31:0]);
      phi_r <= PHI_W'(rand_r) * PHI_W'(total[TW-1:32]);
    end
    if (ph_r == PH_MUL2) begin
      x_r <= XW'(plo_r) + (XW'(phi_r) << 32);
    end
  end

  // Passed buckets give the size; all passed means no bucket held
  assign count    = chain_w[MAX_SIZES-1][NW-1:0];
  assign size_nxt = (count == n_eff) ? SIZE_W'(1) : SIZE_W'(count + NW'(1));
  assign out_load = (ph_r == PH_DONE) && (!out_valid_r || out_ready);

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_size_r <= size_nxt;
    end
  end

endmodule

[tb/sv/tb_weighted_random_size_picker_core.sv]
// Self-checking testbench for weighted_random_size_picker_core: loads are tracked and draws
// are predicted in the bench and each package size is compared on arrival.
// Depends on wrsp_pkg and the picker RTL; reads no files.
module tb_weighted_random_size_picker_core import wrsp_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_SIZES     = 16;
  localparam int CLK_PERIOD    = 10;
  localparam int DRAW_LATENCY  = 70;
  localparam int SETTLE_CYCLES = DRAW_LATENCY + 20;
  localparam int HOLD_CYCLES   = 400;
  localparam int NUM_PHASES    = 8;
  localparam int PHASE_ITEMS   = 47;
  localparam int HOLD_PHASE    = 2;
  localparam int CYCLE_LIMIT   = 400000;
  localparam logic [RAND_W-1:0] RAND_FULL = 31'h7FFF_FFFF;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

  // One line of the directed script; fixed_size of zero means "ask the predictor"
  typedef struct packed {
    row_kind_t              kind;
    logic                   func;
    logic [IDX_W-1:0]       idx;
    logic [TIME_W-1:0]      tt;
    logic [RAND_W-1:0]      rnd;
    logic [CFG_IDX_W-1:0]   reg_idx;
    logic [CFG_DATA_W-1:0]  reg_val;
    logic [SIZE_W-1:0]      fixed_size;
  } script_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic                  in_func;
  logic [IDX_W-1:0]      in_entry_index;
  logic [TIME_W-1:0]     in_turnaround;
  logic [RAND_W-1:0]     in_random_value;
  logic [SIZE_W-1:0]     in_fixed_size;
  logic                  out_valid;
  logic                  out_ready;
  logic [SIZE_W-1:0]     out_package_size;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Bench copy of the picker state
  logic [TIME_W-1:0]     size_times [MAX_SIZES];
  logic                  cur_mode;
  logic [CFG_DATA_W-1:0] cur_count;
  logic [SIZE_W-1:0]     expected_sizes [$];

  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  bit          stall_on = 1'b1;
  bit          hold_pending = 1'b0;

  weighted_random_size_picker_core #(.MAX_SIZES(MAX_SIZES)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_func          (in_func),
    .in_entry_index   (in_entry_index),
    .in_turnaround    (in_turnaround),
    .in_random_value  (in_random_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_package_size (out_package_size),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Weight of one entry under the current mode
  function automatic logic [63:0] entry_weight(int i, logic [63:0] time_sum);
    logic [63:0] t;
    logic [63:0] q;
    t = 64'(size_times[i]);
    if (cur_mode == MODE_INVERSE) begin
      if (t == 0) return 64'd65536;
      q = 64'h1_0000_0000 / t;
      return (q > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : q;
    end
    if (time_sum == 0) return 64'd1;
    return time_sum - t;
  endfunction

  // Roulette pick: bucket i when prefix_i*FULL <= rnd*total < prefix_i+1*FULL
  function automatic logic [SIZE_W-1:0] pick_size(logic [RAND_W-1:0] rnd);
    int unsigned  n;
    logic [63:0]  time_sum;
    logic [63:0]  total;
    logic [63:0]  prefix;
    logic [63:0]  nxt;
    logic [127:0] scaled;
    logic [127:0] lo_b;
    logic [127:0] hi_b;
    logic [127:0] wide_a;
    logic [127:0] wide_b;
    logic [127:0] full_w;
    n = (cur_count == 0) ? 1 :
        ((int'(cur_count) > MAX_SIZES) ? MAX_SIZES : int'(cur_count));
    time_sum = '0;
    for (int i = 0; i < n; i++) time_sum += 64'(size_times[i]);
    total = '0;
    for (int i = 0; i < n; i++) total += entry_weight(i, time_sum);
    if (total == 0) return SIZE_W'(1);
    wide_a = 128'(rnd);
    wide_b = 128'(total);
    scaled = wide_a * wide_b;
    full_w = 128'(RAND_FULL);
    prefix = '0;
    for (int i = 0; i < n; i++) begin
      nxt = prefix + entry_weight(i, time_sum);
      wide_a = 128'(prefix);
      wide_b = 128'(nxt);
      lo_b = wide_a * full_w;
      hi_b = wide_b * full_w;
      if (lo_b <= scaled && scaled < hi_b) return SIZE_W'(i + 1);
      prefix = nxt;
    end
    return SIZE_W'(1);
  endfunction

  function automatic script_row_t draw_row(logic [RAND_W-1:0] rnd, logic [SIZE_W-1:0] fixed);
    script_row_t r;
    r = '0;
    r.kind = ROW_REQ;
    r.func = FUNC_DRAW;
    r.idx = IDX_W'($urandom());
    r.tt = $urandom();
    r.rnd = rnd;
    r.fixed_size = fixed;
    return r;
  endfunction

  function automatic script_row_t load_row(logic [IDX_W-1:0] idx, logic [TIME_W-1:0] tt);
    script_row_t r;
    r = '0;
    r.kind = ROW_REQ;
    r.func = FUNC_LOAD;
    r.idx = idx;
    r.tt = tt;
    r.rnd = RAND_W'($urandom());
    return r;
  endfunction

  function automatic script_row_t cfg_row(logic [CFG_IDX_W-1:0] ri, logic [CFG_DATA_W-1:0] rv);
    script_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.reg_idx = ri;
    r.reg_val = rv;
    return r;
  endfunction

  task automatic report_mismatch(string what, int exp_v, int got_v);
    $display("mismatch at cycle %0d: %s, expected %0d, got %0d", cycles, what, exp_v, got_v);
    mismatches++;
  endtask

  // Offer one request, hold it until taken, then maybe leave a gap
  task automatic apply_request(logic func, logic [IDX_W-1:0] idx, logic [TIME_W-1:0] tt,
                               logic [RAND_W-1:0] rnd, logic [SIZE_W-1:0] fixed);
    in_valid        <= 1'b1;
    in_func         <= func;
    in_entry_index  <= idx;
    in_turnaround   <= tt;
    in_random_value <= rnd;
    in_fixed_size   <= fixed;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (stall_on && $urandom_range(0, 2) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  // Register writes only once the picker has drained and settled
  task automatic write_reg(logic [CFG_IDX_W-1:0] ri, logic [CFG_DATA_W-1:0] rv);
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_sizes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= ri;
    cfg_data  <= rv;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Track accepted requests and register writes; predict each draw
  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (size_times[i]) size_times[i] = '0;
      cur_mode  = MODE_BASIC;
      cur_count = 5'd1;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_WEIGHT_MODE: cur_mode = cfg_data[0];
          CFG_SIZE_COUNT:  cur_count = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (in_func == FUNC_LOAD) begin
          size_times[in_entry_index] = in_turnaround;
        end else if (in_fixed_size != 0) begin
          expected_sizes = {expected_sizes, in_fixed_size};
        end else begin
          expected_sizes = {expected_sizes, pick_size(in_random_value)};
        end
      end
    end
  end

  // Result check against the oldest prediction
  always @(posedge clk) begin
    logic [SIZE_W-1:0] exp_size;
    if (rst_n && out_valid && out_ready) begin
      if (expected_sizes.size() == 0) begin
        report_mismatch("package size with no draw pending", 0, int'(out_package_size));
      end else begin
        exp_size = expected_sizes.pop_front();
        if (out_package_size !== exp_size)
          report_mismatch("package_size", int'(exp_size), int'(out_package_size));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d draws outstanding", cycles,
               expected_sizes.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Result side: random stalls, plus one long hold-off to back the picker up
  initial begin
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_pending) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_pending = 1'b0;
      end else if (stall_on && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Stimulus
  initial begin
    script_row_t           script [$];
    logic                  func;
    logic [IDX_W-1:0]      idx;
    logic [TIME_W-1:0]     tt;
    logic [RAND_W-1:0]     rnd;
    logic [CFG_DATA_W-1:0] reg_val;
    int unsigned           n_use;

    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_func         <= FUNC_LOAD;
    in_entry_index  <= '0;
    in_turnaround   <= '0;
    in_random_value <= '0;
    in_fixed_size   <= '0;
    cfg_valid       <= 1'b0;
    cfg_index       <= CFG_WEIGHT_MODE;
    cfg_data        <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset state, size count extremes, full-scale random, both modes
    script = '{
      draw_row(31'd0, 5'd1),
      draw_row(RAND_FULL, 5'd1),
      cfg_row(CFG_SIZE_COUNT, 5'd16),
      draw_row(31'd0, 5'd1),
      draw_row(RAND_FULL, 5'd1),
      draw_row(RAND_FULL - 31'd1, 5'd0),
      load_row(4'd0, 32'hFFFF_FFFF),
      load_row(4'd15, 32'h0000_0000),
      load_row(4'd7, RECIP_ONE),
      load_row(4'd10, 32'h0000_0001),
      draw_row(31'h4000_0000, 5'd0),
      draw_row(31'h0000_0001, 5'd0),
      cfg_row(CFG_WEIGHT_MODE, 5'b00001),
      draw_row(31'd0, 5'd0),
      draw_row(RAND_FULL, 5'd1),
      draw_row(31'h5A5A_5A5A, 5'd0),
      cfg_row(CFG_SIZE_COUNT, 5'd0),
      draw_row(31'h2AAA_AAAA, 5'd1),
      cfg_row(CFG_SIZE_COUNT, 5'd31),
      draw_row(31'h6000_0000, 5'd0),
      cfg_row(CFG_WEIGHT_MODE, 5'b11110),
      load_row(4'd3, 32'h8000_0000),
      draw_row(31'h1234_5678, 5'd0),
      draw_row(31'h7FFF_0000, 5'd0)
    };
    foreach (script[k]) begin
      if (script[k].kind == ROW_CFG)
        write_reg(script[k].reg_idx, script[k].reg_val);
      else
        apply_request(script[k].func, script[k].idx, script[k].tt, script[k].rnd,
                      script[k].fixed_size);
    end

    // Random phases, each with its own register setting
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      reg_val = CFG_DATA_W'($urandom());
      write_reg(CFG_WEIGHT_MODE, reg_val);
      case ($urandom_range(0, 9))
        0:       reg_val = 5'd0;
        1:       reg_val = 5'd1;
        2:       reg_val = 5'd16;
        3:       reg_val = CFG_DATA_W'($urandom_range(17, 31));
        default: reg_val = CFG_DATA_W'($urandom_range(2, 15));
      endcase
      write_reg(CFG_SIZE_COUNT, reg_val);
      n_use = (reg_val == 0) ? 1 :
              ((int'(reg_val) > MAX_SIZES) ? MAX_SIZES : int'(reg_val));
      // quiet final phase: no gaps and no stalls
      if (phase == NUM_PHASES - 1) stall_on = 1'b0;
      if (phase == HOLD_PHASE) hold_pending = 1'b1;

      repeat (PHASE_ITEMS) begin
        func = ($urandom_range(0, 9) < 6) ? FUNC_DRAW : FUNC_LOAD;
        idx  = ($urandom_range(0, 3) != 0) ? IDX_W'($urandom_range(0, n_use - 1))
                                           : IDX_W'($urandom());
        case ($urandom_range(0, 5))
          0:       tt = 32'd0;
          1:       tt = $urandom_range(1, 4);
          2:       tt = $urandom_range(1, 32'h0002_0000);
          3:       tt = 32'hFFFF_FFFF - $urandom_range(0, 255);
          default: tt = $urandom();
        endcase
        case ($urandom_range(0, 15))
          0:       rnd = 31'd0;
          1:       rnd = RAND_FULL;
          2:       rnd = RAND_FULL - 31'd1;
          default: rnd = RAND_W'($urandom());
        endcase
        apply_request(func, idx, tt, rnd, 5'd0);
      end
    end

    // Drain and settle
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_sizes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
